// ===== sv/prn_pkg.sv =====
package prn_pkg;

  // Field and arithmetic widths
  localparam int unsigned P_W      = 32;  // pressure, rhs, Q16.16
  localparam int unsigned D2_W     = 35;  // exact second difference, signed
  localparam int unsigned MAG_W    = 34;  // magnitude of a second difference
  localparam int unsigned KH_W     = 16;  // half of a Q16.16 scale factor
  localparam int unsigned PP_W     = 50;  // partial product of MAG_W x KH_W
  localparam int unsigned RES_W    = 53;  // residual before saturation, signed
  localparam int unsigned SQ_W     = 64;  // square and running sum, Q32.32
  localparam int unsigned GRID_W   = 11;  // grid size registers

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_INV_DX_SQ   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_DY_SQ   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INV_CELLS   = 3'd4;

  localparam logic [31:0]       RST_INV_SQ    = 32'd65536;
  localparam logic [GRID_W-1:0] RST_GRID      = 11'd1024;
  localparam logic [31:0]       RST_INV_CELLS = 32'd4096;
  localparam int unsigned       MIN_GRID      = 3;

  typedef struct packed {
    logic signed [P_W-1:0] pressure;
    logic signed [P_W-1:0] rhs_value;
    logic                  inner_fluid;
  } prn_in_t;

  typedef struct packed {
    logic [SQ_W-1:0] mean_residual;
    logic            saturated;
  } prn_out_t;

  // Request to the residual square unit
  typedef struct packed {
    logic                   start;
    logic signed [D2_W-1:0] dx2;
    logic signed [D2_W-1:0] dy2;
    logic signed [P_W-1:0]  rhs;
  } prn_sq_req_t;

  // Answer from the residual square unit
  typedef struct packed {
    logic            done;
    logic [SQ_W-1:0] square;
    logic            sat;
  } prn_sq_rsp_t;

endpackage

// ===== sv/prn_sq_unit.sv =====
module prn_sq_unit
  import prn_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  prn_sq_req_t req_i,
  input  logic [31:0] inv_dx_sq_i,
  input  logic [31:0] inv_dy_sq_i,
  output prn_sq_rsp_t rsp_o
);

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_MX   = 3'd1;
  localparam logic [2:0] U_MY   = 3'd2;
  localparam logic [2:0] U_AY   = 3'd3;
  localparam logic [2:0] U_SAT  = 3'd4;
  localparam logic [2:0] U_SQ   = 3'd5;

  logic [2:0]              state_q, state_d;
  logic signed [D2_W-1:0]  dx2_q, dy2_q;
  logic signed [P_W-1:0]   rhs_q;
  logic [PP_W-1:0]         pp_hi_q, pp_lo_q;
  logic                    neg_q;
  logic signed [RES_W-1:0] res_q;
  logic [31:0]             mag_q;
  logic                    sat_q;
  logic [SQ_W-1:0]         sq_q;
  logic                    done_q;

  logic signed [D2_W-1:0]  d_src;
  logic [D2_W-1:0]         d_abs;
  logic [MAG_W-1:0]        d_mag;
  logic [31:0]             k_sel;
  logic [PP_W-1:0]         q_v;
  logic signed [RES_W-1:0] q_s;
  logic signed [RES_W-1:0] q_signed;
  logic [RES_W-1:0]        res_abs;

  // One shared pair of half-product scale multipliers: x in U_MX, y in U_MY
  always_comb begin
    d_src = (state_q == U_MX) ? dx2_q : dy2_q;
    k_sel = (state_q == U_MX) ? inv_dx_sq_i : inv_dy_sq_i;
    d_abs = d_src[D2_W-1] ? D2_W'(-d_src) : D2_W'(d_src);
    d_mag = d_abs[MAG_W-1:0];
    // floor(m * k / 2^16) from two half products
    q_v      = pp_hi_q + (pp_lo_q >> KH_W);
    q_s      = $signed(RES_W'(q_v));
    q_signed = neg_q ? -q_s : q_s;
    res_abs  = res_q[RES_W-1] ? RES_W'(-res_q) : RES_W'(res_q);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      U_IDLE:  if (req_i.start) state_d = U_MX;
      U_MX:    state_d = U_MY;
      U_MY:    state_d = U_AY;
      U_AY:    state_d = U_SAT;
      U_SAT:   state_d = U_SQ;
      U_SQ:    state_d = U_IDLE;
      default: state_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == U_SQ);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == U_IDLE && req_i.start) begin
      dx2_q <= req_i.dx2;
      dy2_q <= req_i.dy2;
      rhs_q <= req_i.rhs;
    end
    if (state_q == U_MX || state_q == U_MY) begin
      pp_hi_q <= PP_W'(d_mag) * PP_W'(k_sel[31:KH_W]);
      pp_lo_q <= PP_W'(d_mag) * PP_W'(k_sel[KH_W-1:0]);
      neg_q   <= d_src[D2_W-1];
    end
    if (state_q == U_MY) begin
      res_q <= q_signed - RES_W'(rhs_q);
    end
    if (state_q == U_AY) begin
      res_q <= res_q + q_signed;
    end
    if (state_q == U_SAT) begin
      // saturate the magnitude at 2^32-1
      if (|res_abs[RES_W-1:32]) begin
        mag_q <= '1;
        sat_q <= 1'b1;
      end else begin
        mag_q <= res_abs[31:0];
        sat_q <= 1'b0;
      end
    end
    if (state_q == U_SQ) begin
      sq_q <= SQ_W'(mag_q) * SQ_W'(mag_q);
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.square = sq_q;
  assign rsp_o.sat    = sat_q;

endmodule

// ===== sv/poisson_residual_norm_core.sv =====
// Mean squared residual of a five-point Poisson stencil over a streamed grid.
// Feed cells of one grid, ghost ring included, in row-major raster order, one
// transaction per cell; after the last cell a single result transaction
// carries sum((Laplacian - rhs)^2) times inv_cell_count as Q32.32, plus a flag
// that is set when a residual magnitude or the running sum saturated in that
// grid. Only interior cells whose stored inner-fluid bit is set contribute.
// Each cell passes through input capture, a line buffer read and a second
// read of the centre row at the right neighbor; a contributing cell then
// waits while the residual unit walks its shared scale multiplier over x and
// y, saturates and squares. The last cell of a grid then forms the final
// 64 x 32 product and waits while an earlier result is still held; a result
// waiting in the output register does not block new cells.
// Grid sizes are clamped to 3..MAX_COLUMNS and 3..MAX_ROWS. Write the
// configuration only while idle; changes take effect on the next cell.
// The line buffers need no clearing pass: every entry read by a counted cell
// was written by the rows above it.
module poisson_residual_norm_core
  import prn_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS = 1024,
  parameter int unsigned MAX_ROWS    = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  prn_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output prn_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned COL_W  = $clog2(MAX_COLUMNS);
  localparam int unsigned COLS_W = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned ROW_W  = $clog2(MAX_ROWS);
  localparam int unsigned ROWS_W = $clog2(MAX_ROWS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD1  = 3'd1;
  localparam logic [2:0] ST_RD2  = 3'd2;
  localparam logic [2:0] ST_CALC = 3'd3;
  localparam logic [2:0] ST_F1   = 3'd4;
  localparam logic [2:0] ST_F2   = 3'd5;
  localparam logic [2:0] ST_F3   = 3'd6;

  // Configuration registers
  logic [31:0]       inv_dx_sq_q, inv_dy_sq_q, inv_cells_q;
  logic [GRID_W-1:0] grid_cols_q, grid_rows_q;

  // Line buffers: the centre row, and one word per column holding the
  // inner-fluid bit, the rhs and the row above
  logic signed [P_W-1:0] centre_mem [MAX_COLUMNS];
  logic [2*P_W:0]        column_mem [MAX_COLUMNS];
  logic signed [P_W-1:0] centre_rd_q;
  logic [2*P_W:0]        column_rd_q;
  logic signed [P_W-1:0] above_rd;
  logic [P_W:0]          rhsmask_rd;

  // Control and item state
  logic [2:0]            state_q, state_d;
  logic [COL_W-1:0]      col_q, col_d;
  logic [ROW_W-1:0]      row_q, row_d;
  logic [COL_W-1:0]      cidx_q;
  logic                  interior_q, last_q;
  logic                  interior_d, last_d;
  prn_in_t               item_q;
  logic signed [P_W-1:0] mid_q, left_q;
  logic [SQ_W-1:0]       sum_q;
  logic                  ovf_q;
  logic [SQ_W-1:0]       prod_hi_q, prod_lo_q;
  logic                  out_valid_q;
  prn_out_t              out_q;

  logic                  in_acc;
  logic                  out_free;
  logic                  active;
  logic [COLS_W-1:0]     cols_v;
  logic [ROWS_W-1:0]     rows_v;
  logic [COLS_W-1:0]     c_next;
  logic [ROWS_W-1:0]     r_next;
  logic                  end_row;
  logic [COL_W-1:0]      rd_addr;
  logic                  rd_en;
  logic [COL_W-1:0]      nb_addr;
  logic signed [D2_W-1:0] dx2_v, dy2_v;
  logic [SQ_W:0]         sum_ext;
  prn_sq_req_t           sq_req;
  prn_sq_rsp_t           sq_rsp;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign above_rd   = $signed(column_rd_q[P_W-1:0]);
  assign rhsmask_rd = column_rd_q[2*P_W:P_W];
  assign active     = interior_q && rhsmask_rd[P_W];

  // Clamp grid sizes to MIN_GRID and the buffer range
  always_comb begin
    if (32'(grid_cols_q) > 32'(MAX_COLUMNS)) begin
      cols_v = COLS_W'(MAX_COLUMNS);
    end else if (32'(grid_cols_q) < 32'(MIN_GRID)) begin
      cols_v = COLS_W'(MIN_GRID);
    end else begin
      cols_v = COLS_W'(grid_cols_q);
    end
    if (32'(grid_rows_q) > 32'(MAX_ROWS)) begin
      rows_v = ROWS_W'(MAX_ROWS);
    end else if (32'(grid_rows_q) < 32'(MIN_GRID)) begin
      rows_v = ROWS_W'(MIN_GRID);
    end else begin
      rows_v = ROWS_W'(grid_rows_q);
    end
  end

  // Advance the raster counters and classify the incoming cell
  always_comb begin
    c_next     = COLS_W'(col_q) + COLS_W'(1);
    r_next     = ROWS_W'(row_q) + ROWS_W'(1);
    end_row    = (c_next >= cols_v);
    interior_d = (row_q >= ROW_W'(2)) && (col_q != '0) && !end_row;
    last_d     = 1'b0;
    col_d      = col_q;
    row_d      = row_q;
    if (end_row) begin
      col_d = '0;
      if (r_next >= rows_v) begin
        row_d  = '0;
        last_d = 1'b1;
      end else begin
        row_d = r_next[ROW_W-1:0];
      end
    end else begin
      col_d = c_next[COL_W-1:0];
    end
  end

  // Right neighbor address; only meaningful for interior cells
  assign nb_addr = interior_q ? COL_W'(cidx_q + COL_W'(1)) : cidx_q;
  assign rd_addr = (state_q == ST_IDLE) ? col_q : nb_addr;
  assign rd_en   = in_acc || (state_q == ST_RD1);

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      centre_rd_q <= centre_mem[rd_addr];
    end
    if (in_acc) begin
      column_rd_q <= column_mem[col_q];
    end
    if (state_q == ST_RD1) begin
      // shift the column down one row
      column_mem[cidx_q] <= {item_q.inner_fluid, item_q.rhs_value, centre_rd_q};
      centre_mem[cidx_q] <= item_q.pressure;
    end
  end

  // Exact second differences
  always_comb begin
    dx2_v = D2_W'(left_q) - D2_W'(mid_q) - D2_W'(mid_q) + D2_W'(centre_rd_q);
    dy2_v = D2_W'(above_rd) - D2_W'(mid_q) - D2_W'(mid_q) + D2_W'(item_q.pressure);
  end

  always_comb begin
    sq_req.start = (state_q == ST_RD2) && active;
    sq_req.dx2   = dx2_v;
    sq_req.dy2   = dy2_v;
    sq_req.rhs   = $signed(rhsmask_rd[P_W-1:0]);
  end

  prn_sq_unit u_sq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (sq_req),
    .inv_dx_sq_i (inv_dx_sq_q),
    .inv_dy_sq_i (inv_dy_sq_q),
    .rsp_o       (sq_rsp)
  );

  assign sum_ext = {1'b0, sum_q} + {1'b0, sq_rsp.square};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_RD1;
      ST_RD1:  state_d = ST_RD2;
      ST_RD2: begin
        if (active) begin
          state_d = ST_CALC;
        end else begin
          state_d = last_q ? ST_F1 : ST_IDLE;
        end
      end
      ST_CALC: if (sq_rsp.done) state_d = last_q ? ST_F1 : ST_IDLE;
      ST_F1:   state_d = ST_F2;
      ST_F2:   state_d = ST_F3;
      ST_F3:   if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      col_q       <= '0;
      row_q       <= '0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      inv_dx_sq_q <= RST_INV_SQ;
      inv_dy_sq_q <= RST_INV_SQ;
      grid_cols_q <= RST_GRID;
      grid_rows_q <= RST_GRID;
      inv_cells_q <= RST_INV_CELLS;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      // accumulate with saturation at 2^64-1
      if (state_q == ST_CALC && sq_rsp.done) begin
        if (sum_ext[SQ_W]) begin
          sum_q <= '1;
          ovf_q <= 1'b1;
        end else begin
          sum_q <= sum_ext[SQ_W-1:0];
          ovf_q <= ovf_q | sq_rsp.sat;
        end
      end
      if (state_q == ST_F3 && out_free) begin
        sum_q       <= '0;
        ovf_q       <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_INV_DX_SQ: inv_dx_sq_q <= cfg_wdata_i;
          REG_INV_DY_SQ: inv_dy_sq_q <= cfg_wdata_i;
          REG_GRID_COLS: grid_cols_q <= cfg_wdata_i[GRID_W-1:0];
          REG_GRID_ROWS: grid_rows_q <= cfg_wdata_i[GRID_W-1:0];
          REG_INV_CELLS: inv_cells_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // Item payload, neighbor registers and the result datapath
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q     <= in_data_i;
      cidx_q     <= col_q;
      interior_q <= interior_d;
      last_q     <= last_d;
    end
    if (state_q == ST_RD1) begin
      mid_q <= centre_rd_q;
    end
    if (state_q == ST_RD2) begin
      left_q <= mid_q;
    end
    if (state_q == ST_F1) begin
      prod_hi_q <= SQ_W'(sum_q[SQ_W-1:32]) * SQ_W'(inv_cells_q);
    end
    if (state_q == ST_F2) begin
      prod_lo_q <= SQ_W'(sum_q[31:0]) * SQ_W'(inv_cells_q);
    end
    if (state_q == ST_F3 && out_free) begin
      out_q.mean_residual <= prod_hi_q + (prod_lo_q >> 32);
      out_q.saturated     <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_accept_to_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_RD1))
    else $error("accepted cell did not start the line buffer read");

  a_done_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_rsp.done |-> (state_q == ST_CALC))
    else $error("residual unit finished outside the wait state");

  a_result_clears_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_F3 && out_free) |=> (sum_q == '0 && !ovf_q && out_valid_o))
    else $error("result load did not clear the running sum");

  a_skip_no_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD2 && !active) |=> (state_q == ST_IDLE || state_q == ST_F1))
    else $error("non-contributing cell entered the residual path");
`endif

endmodule

// ===== bench/poisson_residual_norm_core_test.sv =====
`timescale 1ns / 1ps

module poisson_residual_norm_core_test;
  import prn_pkg::*;

  localparam int unsigned GRID_MAX_COLS   = 1024;
  localparam int unsigned GRID_MAX_ROWS   = 1024;
  // Register indexes the block does not decode; writes to them must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // Margin for the slowest cell and the closing product to finish
  localparam int unsigned SETTLE_CYCLES   = 24;
  localparam int unsigned DRAIN_LIMIT     = 50000;
  localparam int unsigned HOLD_OFF_CYCLES = 600;
  localparam int unsigned RANDOM_CELLS    = 1300;
  localparam int unsigned NORMS_WANTED    = 48;
  // Phase that stresses the receiver
  localparam int unsigned HOLD_PHASE      = 2;

  typedef enum int unsigned {STYLE_SMOOTH, STYLE_MIXED, STYLE_WILD} cell_style_e;
  typedef enum int unsigned {
    DRAIN_ALWAYS, DRAIN_COIN, DRAIN_THREE_OF_FOUR, DRAIN_SPARSE
  } drain_mode_e;

  // One row of the directed table: the cell, and where the grid closes on a
  // value that is obvious by hand, that value typed in
  typedef struct packed {
    prn_in_t  site;
    logic     typed;
    prn_out_t norm;
  } directed_row_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready;
  prn_in_t               in_data     = '0;
  logic                  out_valid;
  logic                  out_ready   = 1'b0;
  prn_out_t              out_data;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx     = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;

  // Shadow of the configuration, as the block should hold it
  logic [31:0]       dx_scale     = RST_INV_SQ;
  logic [31:0]       dy_scale     = RST_INV_SQ;
  logic [GRID_W-1:0] cols_setting = RST_GRID;
  logic [GRID_W-1:0] rows_setting = RST_GRID;
  logic [31:0]       cell_weight  = RST_INV_CELLS;

  // Shadow of the stencil state
  logic [31:0] line_above  [GRID_MAX_COLS];
  logic [31:0] line_centre [GRID_MAX_COLS];
  logic [31:0] line_rhs    [GRID_MAX_COLS];
  bit          line_fluid  [GRID_MAX_COLS];
  logic [31:0] west_value  = '0;
  int unsigned col_pos     = 0;
  int unsigned row_pos     = 0;
  logic [63:0] square_sum  = '0;
  bit          clipped     = 1'b0;

  prn_out_t    expected_norms [$];
  prn_out_t    oldest_norm;
  int unsigned mismatch_count = 0;
  int unsigned norms_seen     = 0;
  int unsigned random_cells   = 0;
  int unsigned burst_left     = 0;
  bit          hold_off_req   = 1'b0;

  // Three 3x3 grids. Only cell (1,1) is interior; corners never enter the stencil.
  directed_row_t directed_rows [27] = '{
    // flat field, inner cell with rhs -1.0: residual 1.0, mean = weight
    {32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, 64'h0, 1'b0},
    {32'h0000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, 64'h0, 1'b0},
    {32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 64'h0, 1'b0},
    {32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 64'h0, 1'b0},
    {32'h0000_0000, 32'hFFFF_0000, 1'b1, 1'b0, 64'h0, 1'b0},
    {32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 64'h0, 1'b0},
    {32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0, 64'h0, 1'b0},
    {32'h0000_0000, 32'h8000_0000, 1'b0, 1'b0, 64'h0, 1'b0},
    {32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 64'h0000_0000_FFFF_FFFF, 1'b0},
    // most negative centre among most positive neighbors: residual clips
    {32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 64'h0, 1'b0},
    {32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 64'h0, 1'b0},
    {32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 64'h0, 1'b0},
    {32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 64'h0, 1'b0},
    {32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0, 64'h0, 1'b0},
    {32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 64'h0, 1'b0},
    {32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 64'h0, 1'b0},
    {32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 64'h0, 1'b0},
    {32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 64'hFFFF_FFFD_0000_0002, 1'b1},
    // same huge residual, but the inner cell is not fluid: sum and flag cleared
    {32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, 64'h0, 1'b0},
    {32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, 64'h0, 1'b0},
    {32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 64'h0, 1'b0},
    {32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 64'h0, 1'b0},
    {32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 64'h0, 1'b0},
    {32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, 64'h0, 1'b0},
    {32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 64'h0, 1'b0},
    {32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0, 64'h0, 1'b0},
    {32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1, 64'h0, 1'b0}
  };

  poisson_residual_norm_core #(
    .MAX_COLUMNS(GRID_MAX_COLS),
    .MAX_ROWS   (GRID_MAX_ROWS)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: five-point residual, squared and summed over one grid
  // ---------------------------------------------------------------------------

  function automatic int unsigned clamp_grid(logic [GRID_W-1:0] v, int unsigned hi);
    if (v < MIN_GRID) return MIN_GRID;
    if (v > hi) return hi;
    return 32'(v);
  endfunction

  function automatic logic signed [63:0] widen_q16(logic [31:0] w);
    return {{32{w[31]}}, w};
  endfunction

  // Scale a second difference by an unsigned Q16.16 factor, truncating the
  // magnitude toward zero
  function automatic logic signed [63:0] scale_by_inv_sq(logic signed [63:0] diff,
                                                         logic [31:0] k);
    logic [63:0] m;
    logic [63:0] q;
    m = diff[63] ? -diff : diff;
    q = m * {48'd0, k[31:16]} + ((m * {48'd0, k[15:0]}) >> 16);
    return diff[63] ? -$signed(q) : $signed(q);
  endfunction

  // Fold one accepted cell into the shadow state; return 1 when the grid closes
  function automatic bit fold_cell(input prn_in_t site, output prn_out_t norm);
    int unsigned        cols;
    int unsigned        rows;
    int unsigned        c;
    int unsigned        r;
    logic [31:0]        up;
    logic [31:0]        mid;
    logic signed [63:0] pc;
    logic signed [63:0] dx2;
    logic signed [63:0] dy2;
    logic signed [63:0] res;
    logic [63:0]        mag;
    logic [63:0]        sq;
    logic [64:0]        wide_sum;
    logic [63:0]        hi_part;
    logic [63:0]        lo_part;
    logic [63:0]        k64;
    cols = clamp_grid(cols_setting, GRID_MAX_COLS);
    rows = clamp_grid(rows_setting, GRID_MAX_ROWS);
    c    = col_pos;
    r    = row_pos;
    norm = '0;
    if (c < GRID_MAX_COLS) begin
      up  = line_above[c];
      mid = line_centre[c];
      // Interior cell of the row held in the centre buffer
      if (r >= 2 && c >= 1 && c + 1 < cols && line_fluid[c]) begin
        pc  = widen_q16(mid);
        dx2 = widen_q16(west_value) - 2 * pc + widen_q16(line_centre[c + 1]);
        dy2 = widen_q16(up) - 2 * pc + widen_q16(site.pressure);
        res = scale_by_inv_sq(dx2, dx_scale) + scale_by_inv_sq(dy2, dy_scale)
              - widen_q16(line_rhs[c]);
        mag = res[63] ? -res : res;
        if (mag > 64'h0000_0000_FFFF_FFFF) begin
          mag     = 64'h0000_0000_FFFF_FFFF;
          clipped = 1'b1;
        end
        sq       = mag * mag;
        wide_sum = {1'b0, square_sum} + {1'b0, sq};
        if (wide_sum[64]) begin
          square_sum = '1;
          clipped    = 1'b1;
        end else begin
          square_sum = wide_sum[63:0];
        end
      end
      line_above[c]  = mid;
      line_centre[c] = site.pressure;
      line_rhs[c]    = site.rhs_value;
      line_fluid[c]  = site.inner_fluid;
      west_value     = mid;
    end
    c++;
    if (c >= cols) begin
      c = 0;
      r++;
      if (r >= rows) begin
        hi_part = {32'd0, square_sum[63:32]};
        lo_part = {32'd0, square_sum[31:0]};
        k64     = {32'd0, cell_weight};
        norm.mean_residual = hi_part * k64 + ((lo_part * k64) >> 32);
        norm.saturated     = clipped;
        square_sum = '0;
        clipped    = 1'b0;
        col_pos    = 0;
        row_pos    = 0;
        return 1'b1;
      end
    end
    col_pos = c;
    row_pos = r;
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Write one register; hold the write enable, the caller drops it after a batch
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_INV_DX_SQ: dx_scale     = data;
      REG_INV_DY_SQ: dy_scale     = data;
      REG_GRID_COLS: cols_setting = data[GRID_W-1:0];
      REG_GRID_ROWS: rows_setting = data[GRID_W-1:0];
      REG_INV_CELLS: cell_weight  = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one cell in the current burst; open a new burst after a random gap.
  // Fold it into the predictor once the transaction completes.
  task automatic push_cell(input prn_in_t site, input bit typed, input prn_out_t typed_norm);
    int unsigned gap;
    prn_out_t    norm;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_data  <= site;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    if (fold_cell(site, norm)) expected_norms.push_back(typed ? typed_norm : norm);
  endtask

  // Wait until every grid has reported, then let the pipeline settle
  task automatic wait_for_quiet();
    int unsigned guard;
    guard = 0;
    while (expected_norms.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_word(cell_style_e style);
    int unsigned pick;
    case (style)
      STYLE_WILD:  pick = $urandom_range(0, 7);
      STYLE_MIXED: pick = $urandom_range(0, 63);
      default:     pick = 63;
    endcase
    case (pick)
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4, 5:    return $urandom();
      // within about +-16.0 in Q16.16
      default: return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
    endcase
  endfunction

  function automatic prn_in_t make_cell(cell_style_e style);
    prn_in_t site;
    site.pressure    = pick_word(style);
    site.rhs_value   = pick_word(style);
    site.inner_fluid = ($urandom_range(0, 3) != 0);
    return site;
  endfunction

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return RST_INV_SQ;
      4:       return $urandom();
      default: return $urandom_range(32'h0000_4000, 32'h0004_0000);
    endcase
  endfunction

  // Grid size word: mostly small sizes, sometimes below the floor or with
  // junk above the 11 decoded bits
  function automatic logic [31:0] grid_word(int unsigned top);
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, MIN_GRID - 1);
      1:       return ($urandom() & 32'hFFFF_F800) | $urandom_range(MIN_GRID, top);
      default: return $urandom_range(MIN_GRID, top);
    endcase
  endfunction

  // One configuration setting followed by whole grids
  task automatic run_phase(input int unsigned phase);
    int unsigned cells;
    int unsigned grids;
    int unsigned interior;
    cell_style_e style;
    case (phase)
      HOLD_PHASE: begin
        write_reg(REG_GRID_COLS, MIN_GRID);
        write_reg(REG_GRID_ROWS, MIN_GRID);
        grids = 8;
      end
      default: begin
        write_reg(REG_GRID_COLS, grid_word(10));
        write_reg(REG_GRID_ROWS, grid_word(8));
        grids = $urandom_range(1, 4);
      end
    endcase
    if ($urandom_range(0, 1) == 0) write_reg(REG_INV_DX_SQ, pick_scale());
    if ($urandom_range(0, 1) == 0) write_reg(REG_INV_DY_SQ, pick_scale());
    if ($urandom_range(0, 1) == 0) begin
      interior = (clamp_grid(cols_setting, GRID_MAX_COLS) - 2)
                 * (clamp_grid(rows_setting, GRID_MAX_ROWS) - 2);
      case ($urandom_range(0, 5))
        0:       write_reg(REG_INV_CELLS, 32'h0000_0000);
        1:       write_reg(REG_INV_CELLS, 32'hFFFF_FFFF);
        2:       write_reg(REG_INV_CELLS, $urandom());
        default: write_reg(REG_INV_CELLS, 32'hFFFF_FFFF / interior);
      endcase
    end
    if ($urandom_range(0, 4) == 0)
      write_reg(CFG_IDX_W'(REG_SPARE_LO + $urandom_range(0, 2)), $urandom());
    cfg_we <= 1'b0;

    case ($urandom_range(0, 19))
      0, 1, 2:                 style = STYLE_WILD;
      3, 4, 5, 6, 7, 8, 9:     style = STYLE_MIXED;
      default:                 style = STYLE_SMOOTH;
    endcase
    // Hold the receiver off so results back up and the block stalls its input
    if (phase == HOLD_PHASE) hold_off_req = 1'b1;

    cells = clamp_grid(cols_setting, GRID_MAX_COLS) * clamp_grid(rows_setting, GRID_MAX_ROWS)
            * grids;
    for (int unsigned i = 0; i < cells; i++) push_cell(make_cell(style), 1'b0, '0);
    in_valid <= 1'b0;
    random_cells += cells;
    wait_for_quiet();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready pattern in spans of random length, with one
  // long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned span;
    drain_mode_e drain_mode;
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        drain_mode = drain_mode_e'($urandom_range(0, 3));
        span       = $urandom_range(8, 80);
        for (int unsigned tick = 0; tick < span; tick++) begin
          case (drain_mode)
            DRAIN_ALWAYS:        out_ready <= 1'b1;
            DRAIN_COIN:          out_ready <= 1'($urandom_range(0, 1));
            DRAIN_THREE_OF_FOUR: out_ready <= (tick % 4 != 3);
            default:             out_ready <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: compare every result transaction with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      norms_seen++;
      if (expected_norms.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with nothing expected: mean %h sat %b",
                   $time, out_data.mean_residual, out_data.saturated);
      end else begin
        oldest_norm = expected_norms.pop_front();
        if (out_data.mean_residual !== oldest_norm.mean_residual ||
            out_data.saturated !== oldest_norm.saturated) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: mismatch: expected mean %h sat %b, got mean %h sat %b",
                     $time, oldest_norm.mean_residual, oldest_norm.saturated,
                     out_data.mean_residual, out_data.saturated);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned phase;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Smallest grid through clamping from below and masking of the upper
    // bits; unit spacing; full weight, so a unit residual reads back one LSB under 1.0
    write_reg(REG_GRID_COLS, 32'd2);
    write_reg(REG_GRID_ROWS, 32'hFFFF_F800);
    write_reg(REG_INV_DX_SQ, RST_INV_SQ);
    write_reg(REG_INV_DY_SQ, RST_INV_SQ);
    write_reg(REG_INV_CELLS, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_LO, 32'h0000_0400);
    write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
    cfg_we <= 1'b0;

    foreach (directed_rows[i])
      push_cell(directed_rows[i].site, directed_rows[i].typed, directed_rows[i].norm);
    in_valid <= 1'b0;
    wait_for_quiet();

    phase = 0;
    while (random_cells < RANDOM_CELLS || norms_seen < NORMS_WANTED) begin
      run_phase(phase);
      phase++;
    end

    wait_for_quiet();
    if (expected_norms.size() != 0) begin
      mismatch_count++;
      $display("%0d expected results never arrived", expected_norms.size());
    end
    if (mismatch_count == 0) begin
      $display("PASS poisson_residual_norm_core");
    end else begin
      $display("FAIL poisson_residual_norm_core");
    end
    $finish;
  end

  // Hard stop
  initial begin
    #4_000_000;
    $display("FAIL poisson_residual_norm_core");
    $finish;
  end

endmodule
